// ===== hdl/u16u8_pkg.sv =====
// Package for the UTF-16BE to UTF-8 transcoder.
// Beat types, the front-to-back descriptor and UTF-8 byte helpers.
// No dependencies.
`timescale 1ns / 1ps

package u16u8_pkg;

	// Input beat: one UTF-16 code unit
	typedef struct packed {
		logic [15:0] code_unit;
		logic        last_unit;
	} in_item_t;

	// Output beat: one UTF-8 byte or a bare end marker
	typedef struct packed {
		logic [7:0] out_byte;
		logic       byte_valid;
		logic       run_last;
		logic       string_end;
	} out_item_t;

	// What the main part of a descriptor emits
	typedef enum logic [1:0] {
		MK_NONE  = 2'd0,
		MK_POINT = 2'd1,
		MK_BARE  = 2'd2
	} main_kind_t;

	// Work for the back end: optional U+FFFD prefix, then the main part
	typedef struct packed {
		logic       pre_fffd;
		main_kind_t kind;
		logic [20:0] cp;
		logic       ends;
	} desc_t;

	localparam logic [20:0] CP_REPLACEMENT = 21'h00FFFD;
	localparam logic [20:0] CP_SUPP_BASE   = 21'h010000;
	localparam logic [5:0]  SUR_HIGH_TAG   = 6'b110110;
	localparam logic [5:0]  SUR_LOW_TAG    = 6'b110111;
	localparam logic [7:0]  LEAD2          = 8'hC0;
	localparam logic [7:0]  LEAD3          = 8'hE0;
	localparam logic [7:0]  LEAD4          = 8'hF0;
	localparam logic [7:0]  CONT_TAG       = 8'h80;

	// Index of the final byte of the encoding (byte count minus one)
	function automatic logic [1:0] utf8_last_idx(input logic [20:0] cp);
		logic [1:0] r;
		if (cp[20:7] == 14'd0) begin
			r = 2'd0;
		end else if (cp[20:11] == 10'd0) begin
			r = 2'd1;
		end else if (cp[20:16] == 5'd0) begin
			r = 2'd2;
		end else begin
			r = 2'd3;
		end
		return r;
	endfunction

	// Byte idx of the encoding of cp, whose final index is last_idx
	function automatic logic [7:0] utf8_byte(input logic [20:0] cp,
			input logic [1:0] idx, input logic [1:0] last_idx);
		logic [7:0] r;
		logic [1:0] remain;
		remain = last_idx - idx;
		if (last_idx == 2'd0) begin
			r = cp[7:0];
		end else if (idx == 2'd0) begin
			unique case (last_idx)
				2'd1:    r = LEAD2 | {3'd0, cp[10:6]};
				2'd2:    r = LEAD3 | {4'd0, cp[15:12]};
				default: r = LEAD4 | {5'd0, cp[20:18]};
			endcase
		end else begin
			unique case (remain)
				2'd0:    r = CONT_TAG | {2'd0, cp[5:0]};
				2'd1:    r = CONT_TAG | {2'd0, cp[11:6]};
				default: r = CONT_TAG | {2'd0, cp[17:12]};
			endcase
		end
		return r;
	endfunction

endpackage

// ===== hdl/u16u8_front.sv =====
// Front end: accepts code units, tracks surrogate and termination state,
// and pushes a descriptor for the back end when a unit yields output. Uses u16u8_pkg.
`timescale 1ns / 1ps

module u16u8_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                valid,
	input  u16u8_pkg::in_item_t item,
	input  logic                full,
	output logic                stall,
	output logic                push,
	output u16u8_pkg::desc_t    desc
);
	import u16u8_pkg::*;

	logic       high_pending_q;
	logic [9:0] high_bits_q;
	logic       terminated_q;

	logic       accept;
	logic       is_high;
	logic       is_low;
	logic       is_zero;
	logic       nxt_high_pending;
	logic [9:0] nxt_high_bits;
	logic       nxt_terminated;

	assign stall   = full;
	assign accept  = valid && !full;
	assign is_high = (item.code_unit[15:10] == SUR_HIGH_TAG);
	assign is_low  = (item.code_unit[15:10] == SUR_LOW_TAG);
	assign is_zero = (item.code_unit == 16'd0);

	// Classify the unit against the held state
	always_comb begin
		desc             = '0;
		desc.kind        = MK_NONE;
		desc.ends        = item.last_unit;
		nxt_high_pending = 1'b0;
		nxt_high_bits    = 10'd0;
		nxt_terminated   = 1'b0;
		push             = 1'b0;
		if (terminated_q) begin
			nxt_terminated = !item.last_unit;
		end else if (high_pending_q && is_low) begin
			// surrogate pair completes
			desc.kind = MK_POINT;
			desc.cp   = CP_SUPP_BASE + {1'b0, high_bits_q, item.code_unit[9:0]};
			push      = 1'b1;
		end else begin
			desc.pre_fffd = high_pending_q;
			priority if (is_zero) begin
				desc.ends      = 1'b1;
				nxt_terminated = !item.last_unit;
				desc.kind      = high_pending_q ? MK_NONE : MK_BARE;
			end else if (is_high) begin
				if (item.last_unit) begin
					desc.kind = MK_POINT;
					desc.cp   = CP_REPLACEMENT;
				end else begin
					nxt_high_pending = 1'b1;
					nxt_high_bits    = item.code_unit[9:0];
				end
			end else if (is_low) begin
				desc.kind = MK_POINT;
				desc.cp   = CP_REPLACEMENT;
			end else begin
				desc.kind = MK_POINT;
				desc.cp   = {5'd0, item.code_unit};
			end
			push = desc.pre_fffd || (desc.kind != MK_NONE);
		end
		push = push && accept;
	end

	// State update on each accepted beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			high_pending_q <= 1'b0;
			high_bits_q    <= 10'd0;
			terminated_q   <= 1'b0;
		end else if (accept) begin
			high_pending_q <= nxt_high_pending;
			high_bits_q    <= nxt_high_bits;
			terminated_q   <= nxt_terminated;
		end
	end

endmodule

// ===== hdl/u16u8_queue.sv =====
// Descriptor queue between front and back ends, register based.
// Uses u16u8_pkg for the descriptor type.
`timescale 1ns / 1ps

module u16u8_queue #(
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  u16u8_pkg::desc_t wr_desc,
	input  logic             pop,
	output logic             full,
	output logic             nonempty,
	output u16u8_pkg::desc_t head
);
	import u16u8_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	desc_t              entry_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;
	logic               do_push;
	logic               do_pop;

	assign full     = (count_q == CNT_W'(DEPTH));
	assign nonempty = (count_q != '0);
	assign head     = entry_q[rd_ptr_q];
	assign do_push  = push && !full;
	assign do_pop   = pop && nonempty;

	// Storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= wr_desc;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== hdl/u16u8_back.sv =====
// Back end: walks each descriptor one UTF-8 byte per cycle, while the output
// register is empty or not stalled, into that register. Uses u16u8_pkg.
`timescale 1ns / 1ps

module u16u8_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 nonempty,
	input  u16u8_pkg::desc_t     head,
	output logic                 pop,
	output logic                 valid,
	input  logic                 stall,
	output u16u8_pkg::out_item_t item
);
	import u16u8_pkg::*;

	logic [1:0] idx_q;
	logic       pre_done_q;
	logic       out_valid_q;
	out_item_t  out_q;

	logic        load;
	logic        in_prefix;
	logic        is_bare;
	logic [20:0] cur_cp;
	logic [1:0]  last_idx;
	logic        seg_last;
	logic        final_beat;
	out_item_t   nxt_out;

	assign load       = nonempty && (!out_valid_q || !stall);
	assign in_prefix  = head.pre_fffd && !pre_done_q;
	assign cur_cp     = in_prefix ? CP_REPLACEMENT : head.cp;
	assign is_bare    = !in_prefix && (head.kind == MK_BARE);
	assign last_idx   = utf8_last_idx(cur_cp);
	assign seg_last   = is_bare || (idx_q == last_idx);
	assign final_beat = seg_last && (!in_prefix || head.kind == MK_NONE);
	assign pop        = load && final_beat;

	// Build the next byte
	always_comb begin
		nxt_out            = '0;
		nxt_out.byte_valid = !is_bare;
		nxt_out.out_byte   = is_bare ? 8'd0 : utf8_byte(cur_cp, idx_q, last_idx);
		nxt_out.run_last   = final_beat;
		nxt_out.string_end = final_beat && head.ends;
	end

	// Byte position within the descriptor
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q      <= 2'd0;
			pre_done_q <= 1'b0;
		end else if (load) begin
			if (final_beat) begin
				idx_q      <= 2'd0;
				pre_done_q <= 1'b0;
			end else if (seg_last) begin
				idx_q      <= 2'd0;
				pre_done_q <= 1'b1;
			end else begin
				idx_q <= idx_q + 2'd1;
			end
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_valid_q || !stall) begin
			out_valid_q <= nonempty;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_q <= nxt_out;
		end
	end

	assign valid = out_valid_q;
	assign item  = out_q;

endmodule

// ===== hdl/utf16be_to_utf8_transcoder.sv =====
// UTF-16BE to UTF-8 transcoder. The first byte of an accepted unit passes
// through the descriptor queue and then the output register. Throughput:
// one output beat per cycle while dst_stall is low; a unit gives 0-6 bytes,
// which the single byte-serializing back end emits in turn. Units enter one
// per cycle while the descriptor queue (QUEUE_DEPTH entries) has room.
// Reset: arst_n clears surrogate, termination, queue and output state.
`timescale 1ns / 1ps

module utf16be_to_utf8_transcoder #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 src_valid,
	output logic                 src_stall,
	input  u16u8_pkg::in_item_t  src_item,
	output logic                 dst_valid,
	input  logic                 dst_stall,
	output u16u8_pkg::out_item_t dst_item
);
	import u16u8_pkg::*;

	logic  push;
	logic  pop;
	logic  full;
	logic  nonempty;
	desc_t wr_desc;
	desc_t head;

	u16u8_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.valid  (src_valid),
		.item   (src_item),
		.full   (full),
		.stall  (src_stall),
		.push   (push),
		.desc   (wr_desc)
	);

	u16u8_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.wr_desc  (wr_desc),
		.pop      (pop),
		.full     (full),
		.nonempty (nonempty),
		.head     (head)
	);

	u16u8_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.nonempty (nonempty),
		.head     (head),
		.pop      (pop),
		.valid    (dst_valid),
		.stall    (dst_stall),
		.item     (dst_item)
	);

endmodule
